FILE: hdl/tps_pkg.sv
package tps_pkg;

    localparam int CB        = 32;
    localparam int NW        = 18;
    localparam int OFFW      = 32;
    localparam int PROD_W    = NW + CB;
    localparam int DSUM_W    = PROD_W + 2;
    localparam int SH_W      = DSUM_W - 16;
    localparam int DIST_W    = ((SH_W > OFFW) ? SH_W : OFFW) + 1;
    localparam int S_W       = DIST_W + 1;
    localparam int FRAC      = 61 - CB;
    localparam int KMAX      = (S_W > FRAC) ? (S_W - FRAC) : 0;
    localparam int K_W       = $clog2(KMAX + 2);
    localparam int DEL_W     = CB + 1;
    localparam int Q_W       = DEL_W;
    localparam int DIVD_W    = DEL_W + FRAC;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = (Q_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int LANES     = 6;
    localparam int LATENCY   = 4 + DIV_STAGES + 1;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_AC = 2'd2;

    localparam logic [1:0] REG_NX  = 2'd0;
    localparam logic [1:0] REG_NY  = 2'd1;
    localparam logic [1:0] REG_NZ  = 2'd2;
    localparam logic [1:0] REG_OFF = 2'd3;

    typedef struct packed {
        logic signed [CB-1:0] a_x;
        logic signed [CB-1:0] a_y;
        logic signed [CB-1:0] a_z;
        logic signed [CB-1:0] b_x;
        logic signed [CB-1:0] b_y;
        logic signed [CB-1:0] b_z;
        logic signed [CB-1:0] c_x;
        logic signed [CB-1:0] c_y;
        logic signed [CB-1:0] c_z;
    } in_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CB-1:0] start_x;
        logic signed [CB-1:0] start_y;
        logic signed [CB-1:0] start_z;
        logic signed [CB-1:0] end_x;
        logic signed [CB-1:0] end_y;
        logic signed [CB-1:0] end_z;
        logic [1:0]           start_edge;
        logic [1:0]           end_edge;
    } out_t;

    typedef struct packed {
        in_t                      vtx;
        logic signed [DIST_W-1:0] d0;
        logic signed [DIST_W-1:0] d1;
        logic signed [DIST_W-1:0] d2;
    } dist_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [1:0]        es;
        logic [1:0]        ee;
    } meta_t;

    typedef struct packed {
        logic [DIVD_W-1:0]    dividend;
        logic [FRAC-1:0]      ns;
        logic signed [CB-1:0] pa;
        logic                 neg;
    } lane_t;

    function automatic logic signed [CB-1:0] vtx(input in_t t, input logic [1:0] v,
                                                 input logic [1:0] ax);
        logic signed [CB-1:0] r;
        case ({v, ax})
            4'b0000: r = t.a_x;
            4'b0001: r = t.a_y;
            4'b0010: r = t.a_z;
            4'b0100: r = t.b_x;
            4'b0101: r = t.b_y;
            4'b0110: r = t.b_z;
            4'b1000: r = t.c_x;
            4'b1001: r = t.c_y;
            4'b1010: r = t.c_z;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/tps_dist.sv
module tps_dist (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  tps_pkg::in_t                  tri_in,
    input  logic signed [tps_pkg::NW-1:0] nx,
    input  logic signed [tps_pkg::NW-1:0] ny,
    input  logic signed [tps_pkg::NW-1:0] nz,
    input  logic signed [tps_pkg::OFFW-1:0] off,
    output logic                          out_valid,
    output tps_pkg::dist_t                dist_data
);

    logic signed [tps_pkg::PROD_W-1:0] prod_next [3][3];
    logic signed [tps_pkg::PROD_W-1:0] prod_reg  [3][3];
    tps_pkg::in_t                      vtx1_reg;
    logic                              v1_reg;
    logic                              v2_reg;
    tps_pkg::dist_t                    dist_next;
    tps_pkg::dist_t                    dist_reg;
    logic signed [tps_pkg::DIST_W-1:0] d_c [3];

    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            prod_next[v][0] = nx * tps_pkg::vtx(tri_in, 2'(v), 2'd0);
            prod_next[v][1] = ny * tps_pkg::vtx(tri_in, 2'(v), 2'd1);
            prod_next[v][2] = nz * tps_pkg::vtx(tri_in, 2'(v), 2'd2);
        end
    end

    always_comb
    begin
        logic signed [tps_pkg::DSUM_W-1:0] sum;
        logic signed [tps_pkg::SH_W-1:0]   sh;
        for (int v = 0; v < 3; v++)
        begin
            sum = tps_pkg::DSUM_W'(prod_reg[v][0]) + tps_pkg::DSUM_W'(prod_reg[v][1])
                + tps_pkg::DSUM_W'(prod_reg[v][2]);
            sh = sum[tps_pkg::DSUM_W-1:16];
            d_c[v] = tps_pkg::DIST_W'(sh) + tps_pkg::DIST_W'(off);
        end
        dist_next.vtx = vtx1_reg;
        dist_next.d0  = d_c[0];
        dist_next.d1  = d_c[1];
        dist_next.d2  = d_c[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        vtx1_reg <= tri_in;
        dist_reg <= dist_next;
    end

    assign out_valid = v2_reg;
    assign dist_data = dist_reg;

endmodule

FILE: hdl/tps_setup.sv
module tps_setup (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  tps_pkg::dist_t                        dist_data,
    output tps_pkg::meta_t                        meta,
    output tps_pkg::lane_t [tps_pkg::LANES-1:0]   lanes
);

    tps_pkg::meta_t                    meta3_next, meta3_reg, meta4_reg;
    logic [tps_pkg::FRAC-1:0]          na_next [2];
    logic [tps_pkg::FRAC-1:0]          ns_next [2];
    logic [tps_pkg::FRAC-1:0]          na_reg  [2];
    logic [tps_pkg::FRAC-1:0]          ns_reg  [2];
    logic [tps_pkg::DEL_W-1:0]         dm_next [tps_pkg::LANES];
    logic [tps_pkg::DEL_W-1:0]         dm_reg  [tps_pkg::LANES];
    logic                              neg_next [tps_pkg::LANES];
    logic                              neg_reg  [tps_pkg::LANES];
    logic signed [tps_pkg::CB-1:0]     pa_next [tps_pkg::LANES];
    logic signed [tps_pkg::CB-1:0]     pa_reg  [tps_pkg::LANES];
    tps_pkg::lane_t [tps_pkg::LANES-1:0] lanes_next, lanes_reg;

    always_comb
    begin
        logic signed [tps_pkg::DIST_W-1:0] d [3];
        logic                              pos [3];
        logic                              ngt [3];
        logic                              c0, c1, c2;
        logic [1:0]                        e, ia, ib;
        logic [tps_pkg::DIST_W-1:0]        ua, ub;
        logic [tps_pkg::S_W-1:0]           s;
        logic [tps_pkg::K_W-1:0]           kk;
        logic signed [tps_pkg::DEL_W-1:0]  delta;
        logic signed [tps_pkg::CB-1:0]     pa, pb;

        d[0] = dist_data.d0;
        d[1] = dist_data.d1;
        d[2] = dist_data.d2;
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = !d[i][tps_pkg::DIST_W-1] && (d[i] != '0);
            ngt[i] = d[i][tps_pkg::DIST_W-1];
        end
        c0 = (pos[0] && ngt[1]) || (ngt[0] && pos[1]);
        c1 = (pos[1] && ngt[2]) || (ngt[1] && pos[2]);
        c2 = (pos[0] && ngt[2]) || (ngt[0] && pos[2]);

        meta3_next.valid = in_valid;
        meta3_next.hit   = 1'b1;
        meta3_next.es    = tps_pkg::EDGE_AB;
        meta3_next.ee    = tps_pkg::EDGE_BC;
        if (c0 && c1)
        begin
            meta3_next.es = tps_pkg::EDGE_AB;
            meta3_next.ee = tps_pkg::EDGE_BC;
        end
        else if (c1 && c2)
        begin
            meta3_next.es = tps_pkg::EDGE_BC;
            meta3_next.ee = tps_pkg::EDGE_AC;
        end
        else if (c0 && c2)
        begin
            meta3_next.es = tps_pkg::EDGE_AB;
            meta3_next.ee = tps_pkg::EDGE_AC;
        end
        else
        begin
            meta3_next.hit = 1'b0;
        end

        for (int p = 0; p < 2; p++)
        begin
            e  = (p == 0) ? meta3_next.es : meta3_next.ee;
            ia = (e == tps_pkg::EDGE_BC) ? 2'd1 : 2'd0;
            ib = (e == tps_pkg::EDGE_AB) ? 2'd1 : 2'd2;
            ua = d[ia][tps_pkg::DIST_W-1] ? -d[ia] : d[ia];
            ub = d[ib][tps_pkg::DIST_W-1] ? -d[ib] : d[ib];
            s  = tps_pkg::S_W'(ua) + tps_pkg::S_W'(ub);
            kk = '0;
            for (int k = tps_pkg::KMAX; k >= 0; k--)
            begin
                if ((s >> k) < (tps_pkg::S_W'(1) << tps_pkg::FRAC))
                    kk = tps_pkg::K_W'(k);
            end
            ns_next[p] = tps_pkg::FRAC'(s >> kk);
            na_next[p] = tps_pkg::FRAC'(ua >> kk);
            for (int ax = 0; ax < 3; ax++)
            begin
                pa = tps_pkg::vtx(dist_data.vtx, ia, 2'(ax));
                pb = tps_pkg::vtx(dist_data.vtx, ib, 2'(ax));
                delta = tps_pkg::DEL_W'(pb) - tps_pkg::DEL_W'(pa);
                neg_next[p*3+ax] = delta[tps_pkg::DEL_W-1];
                dm_next[p*3+ax]  = delta[tps_pkg::DEL_W-1] ? -delta : delta;
                pa_next[p*3+ax]  = pa;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < tps_pkg::LANES; l++)
        begin
            lanes_next[l].dividend = tps_pkg::DIVD_W'(dm_reg[l]) * tps_pkg::DIVD_W'(na_reg[l/3])
                                   + tps_pkg::DIVD_W'(ns_reg[l/3] >> 1);
            lanes_next[l].ns  = ns_reg[l/3];
            lanes_next[l].pa  = pa_reg[l];
            lanes_next[l].neg = neg_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta3_reg <= '0;
            meta4_reg <= '0;
        end
        else
        begin
            meta3_reg <= meta3_next;
            meta4_reg <= meta3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg        <= na_next;
        ns_reg        <= ns_next;
        dm_reg        <= dm_next;
        neg_reg       <= neg_next;
        pa_reg        <= pa_next;
        lanes_reg     <= lanes_next;
    end

    assign meta  = meta4_reg;
    assign lanes = lanes_reg;

endmodule

FILE: hdl/tps_div.sv
module tps_div (
    input  logic                          clk,
    input  tps_pkg::lane_t                lane,
    output logic signed [tps_pkg::CB-1:0] point
);

    localparam int NS = tps_pkg::DIV_STAGES;

    logic [tps_pkg::FRAC-1:0]      rem_s [NS+1];
    logic [tps_pkg::Q_W-1:0]       low_s [NS+1];
    logic [tps_pkg::FRAC-1:0]      ns_s  [NS+1];
    logic signed [tps_pkg::CB-1:0] pa_s  [NS+1];
    logic                          neg_s [NS+1];

    assign rem_s[0] = lane.dividend[tps_pkg::DIVD_W-1:tps_pkg::Q_W];
    assign low_s[0] = lane.dividend[tps_pkg::Q_W-1:0];
    assign ns_s[0]  = lane.ns;
    assign pa_s[0]  = lane.pa;
    assign neg_s[0] = lane.neg;

    for (genvar st = 0; st < NS; st++)
    begin : g_stage
        logic [tps_pkg::FRAC-1:0] rem_next;
        logic [tps_pkg::Q_W-1:0]  low_next;
        logic [tps_pkg::FRAC-1:0] rem_reg;
        logic [tps_pkg::Q_W-1:0]  low_reg;
        logic [tps_pkg::FRAC-1:0] ns_reg;
        logic signed [tps_pkg::CB-1:0] pa_reg;
        logic                     neg_reg;

        always_comb
        begin
            logic [tps_pkg::FRAC:0] t;
            rem_next = rem_s[st];
            low_next = low_s[st];
            for (int i = 0; i < tps_pkg::DIV_STEPS; i++)
            begin
                if (st * tps_pkg::DIV_STEPS + i < tps_pkg::Q_W)
                begin
                    t = {rem_next, low_next[tps_pkg::Q_W-1]};
                    low_next = low_next << 1;
                    if (t >= {1'b0, ns_s[st]})
                    begin
                        rem_next    = tps_pkg::FRAC'(t - {1'b0, ns_s[st]});
                        low_next[0] = 1'b1;
                    end
                    else
                    begin
                        rem_next = tps_pkg::FRAC'(t);
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
            ns_reg  <= ns_s[st];
            pa_reg  <= pa_s[st];
            neg_reg <= neg_s[st];
        end

        assign rem_s[st+1] = rem_reg;
        assign low_s[st+1] = low_reg;
        assign ns_s[st+1]  = ns_reg;
        assign pa_s[st+1]  = pa_reg;
        assign neg_s[st+1] = neg_reg;
    end

    // remainder of the last stage is not needed
    logic unused_rem;
    assign unused_rem = ^rem_s[NS];

    assign point = (neg_s[NS] && !unused_rem) || neg_s[NS]
                 ? pa_s[NS] - tps_pkg::CB'(low_s[NS])
                 : pa_s[NS] + tps_pkg::CB'(low_s[NS]);

endmodule

FILE: hdl/triangle_plane_slice_unit.sv
// Channel   Signals                               Direction  Handshake
// request   start, busy, tri_in                   in         start && !busy
// result    done, result                          out        done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in    cfg_valid && cfg_ready
//
// One request per cycle; busy stays low.
// Each result passes through the pipeline: two stages of plane distance,
// two of edge setup and scaling multiply, nine of the 33-bit quotient
// (four bits a stage) and one output register.
// Reset clears valid state and loads the plane registers (nz 65536, rest zero); no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
module triangle_plane_slice_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tps_pkg::in_t        tri_in,
    output logic                done,
    output tps_pkg::out_t       result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [tps_pkg::OFFW-1:0] cfg_data
);

    logic signed [tps_pkg::NW-1:0]   nx_reg, ny_reg, nz_reg;
    logic signed [tps_pkg::OFFW-1:0] off_reg;
    logic                            d_valid;
    tps_pkg::dist_t                  dist_data;
    tps_pkg::meta_t                  meta4;
    tps_pkg::lane_t [tps_pkg::LANES-1:0] lanes;
    logic signed [tps_pkg::CB-1:0]   pt [tps_pkg::LANES];
    tps_pkg::meta_t                  meta_reg [tps_pkg::DIV_STAGES];
    tps_pkg::meta_t                  meta_out;
    logic                            done_reg;
    tps_pkg::out_t                   result_next, result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg  <= '0;
            ny_reg  <= '0;
            nz_reg  <= tps_pkg::NW'(65536);
            off_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tps_pkg::REG_NX:  nx_reg  <= cfg_data[tps_pkg::NW-1:0];
                tps_pkg::REG_NY:  ny_reg  <= cfg_data[tps_pkg::NW-1:0];
                tps_pkg::REG_NZ:  nz_reg  <= cfg_data[tps_pkg::NW-1:0];
                tps_pkg::REG_OFF: off_reg <= cfg_data;
                default:          off_reg <= off_reg;
            endcase
        end
    end

    tps_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .tri_in    (tri_in),
        .nx        (nx_reg),
        .ny        (ny_reg),
        .nz        (nz_reg),
        .off       (off_reg),
        .out_valid (d_valid),
        .dist_data (dist_data)
    );

    tps_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .dist_data (dist_data),
        .meta      (meta4),
        .lanes     (lanes)
    );

    for (genvar l = 0; l < tps_pkg::LANES; l++)
    begin : g_lane
        tps_div u_div (
            .clk   (clk),
            .lane  (lanes[l]),
            .point (pt[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tps_pkg::DIV_STAGES; i++)
                meta_reg[i] <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            meta_reg[0] <= meta4;
            for (int i = 1; i < tps_pkg::DIV_STAGES; i++)
                meta_reg[i] <= meta_reg[i-1];
            done_reg <= meta_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign meta_out = meta_reg[tps_pkg::DIV_STAGES-1];

    always_comb
    begin
        result_next = '0;
        if (meta_out.hit)
        begin
            result_next.hit        = 1'b1;
            result_next.start_x    = pt[0];
            result_next.start_y    = pt[1];
            result_next.start_z    = pt[2];
            result_next.end_x      = pt[3];
            result_next.end_y      = pt[4];
            result_next.end_z      = pt[5];
            result_next.start_edge = meta_out.es;
            result_next.end_edge   = meta_out.ee;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/tps_checker.sv
module tps_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input tps_pkg::out_t result
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(tps_pkg::LATENCY) done)
        else $error("result missing after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, tps_pkg::LATENCY))
        else $error("result without request");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.start_x == '0 && result.end_z == '0
            && result.start_edge == '0 && result.end_edge == '0))
        else $error("miss result not cleared");

    a_edges: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.start_edge != result.end_edge
            && result.end_edge != tps_pkg::EDGE_AB))
        else $error("bad edge pair");

endmodule

bind triangle_plane_slice_unit tps_checker u_tps_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_ITEMS = 60;

    typedef struct {
        tps_pkg::in_t  shape;
        bit            typed;
        tps_pkg::out_t want;
    } slice_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    tps_pkg::in_t        tri_in = '0;
    logic                done;
    tps_pkg::out_t       result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [tps_pkg::OFFW-1:0] cfg_data = '0;

    longint              plane_n [3];
    longint              plane_off;
    tps_pkg::out_t       pending_slices [$];
    slice_row_t          slice_table [$];
    int                  errors = 0;
    int                  requests = 0;
    int                  slices_seen = 0;
    int                  hits_seen = 0;
    int                  idle_cycles = 0;
    bit                  quiet = 1'b0;

    triangle_plane_slice_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .tri_in    (tri_in),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint plane_distance(longint p [3]);
        longint hi;
        longint lo;
        longint ph;
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++)
        begin
            ph = p[i] >>> 16;
            hi += plane_n[i] * ph;
            lo += plane_n[i] * (p[i] - (ph <<< 16));
        end
        return hi + (lo >>> 16) + plane_off;
    endfunction

    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint edge_lerp(longint pa, longint pb, longint da, longint db);
        longint unsigned ua;
        longint unsigned s;
        longint unsigned ns;
        longint unsigned na;
        longint unsigned q;
        longint          delta;
        int              k;
        ua = magnitude(da);
        s = ua + magnitude(db);
        delta = pb - pa;
        k = 0;
        while ((s >> k) >= (64'd1 << tps_pkg::FRAC))
            k++;
        na = ua >> k;
        ns = s >> k;
        if (ns == 0)
            return pa;
        q = (magnitude(delta) * na + ns / 2) / ns;
        return (delta < 0) ? pa - longint'(q) : pa + longint'(q);
    endfunction

    function automatic bit opposite(longint x, longint y);
        return (x > 0 && y < 0) || (x < 0 && y > 0);
    endfunction

    function automatic void cut_at(longint v [3][3], longint d [3], logic [1:0] e,
                                   output logic signed [tps_pkg::CB-1:0] pt [3]);
        int a;
        int b;
        a = (e == tps_pkg::EDGE_BC) ? 1 : 0;
        b = (e == tps_pkg::EDGE_AB) ? 1 : 2;
        for (int i = 0; i < 3; i++)
            pt[i] = tps_pkg::CB'(edge_lerp(v[a][i], v[b][i], d[a], d[b]));
    endfunction

    function automatic tps_pkg::out_t slice_triangle(tps_pkg::in_t t);
        longint              v [3][3];
        longint              d [3];
        logic signed [tps_pkg::CB-1:0] ps [3];
        logic signed [tps_pkg::CB-1:0] pe [3];
        bit                  c0;
        bit                  c1;
        bit                  c2;
        tps_pkg::out_t       r;
        v[0][0] = t.a_x; v[0][1] = t.a_y; v[0][2] = t.a_z;
        v[1][0] = t.b_x; v[1][1] = t.b_y; v[1][2] = t.b_z;
        v[2][0] = t.c_x; v[2][1] = t.c_y; v[2][2] = t.c_z;
        for (int i = 0; i < 3; i++)
            d[i] = plane_distance(v[i]);
        c0 = opposite(d[0], d[1]);
        c1 = opposite(d[1], d[2]);
        c2 = opposite(d[0], d[2]);
        r = '0;
        if (c0 && c1)
        begin
            r.start_edge = tps_pkg::EDGE_AB;
            r.end_edge = tps_pkg::EDGE_BC;
        end
        else if (c1 && c2)
        begin
            r.start_edge = tps_pkg::EDGE_BC;
            r.end_edge = tps_pkg::EDGE_AC;
        end
        else if (c0 && c2)
        begin
            r.start_edge = tps_pkg::EDGE_AB;
            r.end_edge = tps_pkg::EDGE_AC;
        end
        else
            return r;
        cut_at(v, d, r.start_edge, ps);
        cut_at(v, d, r.end_edge, pe);
        r.hit = 1'b1;
        r.start_x = ps[0]; r.start_y = ps[1]; r.start_z = ps[2];
        r.end_x = pe[0]; r.end_y = pe[1]; r.end_z = pe[2];
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s at slice %0d: got %0h, want %0h", field, slices_seen, got,
                 want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_slices.size() == 0)
                report_mismatch("unexpected slice", result.hit, 0);
            else
            begin
                tps_pkg::out_t w;
                w = pending_slices.pop_front();
                if (result.hit !== w.hit) report_mismatch("hit", result.hit, w.hit);
                if (result.start_x !== w.start_x)
                    report_mismatch("start_x", result.start_x, w.start_x);
                if (result.start_y !== w.start_y)
                    report_mismatch("start_y", result.start_y, w.start_y);
                if (result.start_z !== w.start_z)
                    report_mismatch("start_z", result.start_z, w.start_z);
                if (result.end_x !== w.end_x) report_mismatch("end_x", result.end_x, w.end_x);
                if (result.end_y !== w.end_y) report_mismatch("end_y", result.end_y, w.end_y);
                if (result.end_z !== w.end_z) report_mismatch("end_z", result.end_z, w.end_z);
                if (result.start_edge !== w.start_edge)
                    report_mismatch("start_edge", result.start_edge, w.start_edge);
                if (result.end_edge !== w.end_edge)
                    report_mismatch("end_edge", result.end_edge, w.end_edge);
                if (w.hit)
                    hits_seen++;
            end
            slices_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_slices.size() != 0)
            @(posedge clk);
        repeat (tps_pkg::LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [tps_pkg::OFFW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == tps_pkg::REG_OFF)
            plane_off = longint'($signed(val));
        else
            plane_n[idx] = longint'($signed(val[tps_pkg::NW-1:0]));
    endtask

    task automatic set_plane(int nx, int ny, int nz, int off);
        drain();
        write_reg(tps_pkg::REG_NX, nx);
        write_reg(tps_pkg::REG_NY, ny);
        write_reg(tps_pkg::REG_NZ, nz);
        write_reg(tps_pkg::REG_OFF, off);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_triangle(tps_pkg::in_t t, bit typed, tps_pkg::out_t want);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start <= 1'b1;
        tri_in <= t;
        do
            @(posedge clk);
        while (busy);
        pending_slices.insert(pending_slices.size(), typed ? want : slice_triangle(t));
        requests++;
    endtask

    function automatic logic [tps_pkg::CB-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            3: return 32'(int'($urandom_range(0, 65536)) - 32768);
            default: return 32'(int'($urandom_range(0, 2 ** 22)) - 2 ** 21);
        endcase
    endfunction

    function automatic tps_pkg::in_t random_triangle();
        tps_pkg::in_t t;
        t.a_x = pick_coord(); t.a_y = pick_coord(); t.a_z = pick_coord();
        t.b_x = pick_coord(); t.b_y = pick_coord(); t.b_z = pick_coord();
        t.c_x = pick_coord(); t.c_y = pick_coord(); t.c_z = pick_coord();
        if ($urandom_range(0, 7) == 0)
            t.b_z = t.a_z;
        return t;
    endfunction

    function automatic tps_pkg::in_t tri_z(int az, int bz, int cz);
        tps_pkg::in_t t;
        t = '0;
        t.a_z = az;
        t.b_x = 32'sh1_0000;
        t.b_z = bz;
        t.c_y = 32'sh1_0000;
        t.c_z = cz;
        return t;
    endfunction

    task automatic add_row(tps_pkg::in_t t, bit typed, tps_pkg::out_t want);
        slice_row_t r;
        r.shape = t;
        r.typed = typed;
        r.want = want;
        slice_table.insert(slice_table.size(), r);
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            send_triangle(random_triangle(), 1'b0, '0);
        start <= 1'b0;
    endtask

    initial
    begin
        tps_pkg::in_t  t;
        tps_pkg::out_t w;
        plane_n[0] = 0;
        plane_n[1] = 0;
        plane_n[2] = 65536;
        plane_off = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row('0, 1'b1, '0);
        add_row(tri_z(65536, 2, 1), 1'b1, '0);
        add_row(tri_z(-65536, -2, -1), 1'b1, '0);
        add_row('1, 1'b1, '0);
        t = '0;
        t.a_z = 32'sh1_0000;
        t.b_z = -32'sh1_0000;
        t.c_x = 32'sh1_0000;
        t.c_z = -32'sh1_0000;
        w = '0;
        w.hit = 1'b1;
        w.end_x = 32'sh8000;
        w.start_edge = tps_pkg::EDGE_AB;
        w.end_edge = tps_pkg::EDGE_AC;
        add_row(t, 1'b1, w);
        add_row(tri_z(0, 65536, -65536), 1'b1, '0);
        add_row(tri_z(65536, 0, -65536), 1'b1, '0);
        add_row(tri_z(1, -1, 1), 1'b0, '0);
        add_row(tri_z(-3, -7, 65536), 1'b0, '0);
        add_row(tri_z(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000), 1'b0, '0);
        add_row(tri_z(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b1, '0);
        add_row(tri_z(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b1, '0);
        t = '1;
        t.a_z = 32'h7fff_ffff;
        t.b_x = 32'h8000_0000;
        t.c_y = 32'h7fff_ffff;
        add_row(t, 1'b0, '0);
        t = {9{32'h1234_5678}};
        add_row(t, 1'b1, '0);
        t = '0;
        t.a_x = 32'h8000_0000;
        t.a_z = 32'h0000_ffff;
        t.b_x = 32'h7fff_ffff;
        t.b_z = 32'hffff_0001;
        t.c_y = 32'h8000_0000;
        t.c_z = 32'h0000_0001;
        add_row(t, 1'b0, '0);
        foreach (slice_table[i])
            send_triangle(slice_table[i].shape, slice_table[i].typed, slice_table[i].want);

        random_phase(PHASE_ITEMS);
        set_plane(0, 0, 0, 0);
        add_row(tri_z(65536, -65536, 65536), 1'b1, '0);
        send_triangle(slice_table[slice_table.size() - 1].shape, 1'b1, '0);
        random_phase(PHASE_ITEMS);
        set_plane(65536, 0, 0, 32'sh0001_8000);
        random_phase(PHASE_ITEMS);
        set_plane(-65536, 65536, -65536, -12345);
        random_phase(PHASE_ITEMS);
        set_plane(131071, -131072, 131071, 32'h7fff_ffff);
        random_phase(PHASE_ITEMS);
        set_plane(-131072, 131071, -131072, 32'h8000_0000);
        random_phase(PHASE_ITEMS);
        set_plane($urandom(), $urandom(), $urandom(), $urandom_range(0, 2 ** 20));
        random_phase(PHASE_ITEMS);
        set_plane(37837, -37837, 37837, -32'sh0002_0000);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);

        drain();
        $display("Sent %0d triangles over eight plane settings, %0d slices checked, %0d hits.",
                 requests, slices_seen, hits_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
